// ----- rtl/core/bslp_pkg.sv -----
// bslp_pkg: shared types and constants for the button short/long press detector
// used by bslp_track and button_short_long_press_detector_core; no dependencies
package bslp_pkg;

  localparam int unsigned COUNT_BITS_DEFAULT = 16;
  localparam int unsigned THR_W              = 16;
  localparam int unsigned MASK_W             = 3;

  localparam logic [THR_W-1:0] LONG_TICKS_RESET  = 16'd300;
  localparam logic [THR_W-1:0] SHORT_TICKS_RESET = 16'd5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SHORT = 1'b1;

  // pressed mask bit positions
  localparam int unsigned MASK_KEY0 = 0;
  localparam int unsigned MASK_KEY1 = 1;
  localparam int unsigned MASK_WAKE = 2;

  typedef enum logic [1:0] {
    KEY_ZERO = 2'd0,
    KEY_ONE  = 2'd1,
    KEY_WAKE = 2'd2
  } key_e;

  typedef enum logic {
    PH_IDLE = 1'b0,
    PH_HELD = 1'b1
  } phase_e;

  typedef struct packed {
    logic valid;
    key_e key;
    logic long_press;
  } evt_t;

endpackage

// ----- rtl/core/bslp_track.sv -----
// bslp_track: idle/held phase machine, hold counter and press classification
// depends on bslp_pkg
module bslp_track import bslp_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [MASK_W-1:0] mask_i,
  input  logic [THR_W-1:0]  long_ticks_i,
  input  logic [THR_W-1:0]  short_ticks_i,
  output evt_t              evt_o
);

  localparam int unsigned CMP_W = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

  phase_e                phase_q, phase_d;
  logic [MASK_W-1:0]     mask_q;
  logic [COUNT_BITS-1:0] hold_q, hold_d, hold_inc;
  logic [CMP_W-1:0]      inc_x, hold_x, long_x, short_x;
  logic                  same, single;
  key_e                  prev_key;

  assign hold_inc = (&hold_q) ? hold_q : hold_q + 1'b1;
  assign inc_x    = CMP_W'(hold_inc);
  assign hold_x   = CMP_W'(hold_q);
  assign long_x   = CMP_W'(long_ticks_i);
  assign short_x  = CMP_W'(short_ticks_i);
  assign same     = (mask_i == mask_q);
  assign single   = $onehot(mask_q);

  // combination masks can match several arms; the key is only used when single
  always_comb begin
    case (1'b1)
      mask_q[MASK_KEY1]: prev_key = KEY_ONE;
      mask_q[MASK_WAKE]: prev_key = KEY_WAKE;
      default:           prev_key = KEY_ZERO;
    endcase
  end

  always_comb begin
    phase_d          = phase_q;
    hold_d           = hold_q;
    evt_o.valid      = 1'b0;
    evt_o.key        = prev_key;
    evt_o.long_press = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (!same && (mask_i != '0)) begin
          phase_d = PH_HELD;
          hold_d  = '0;
        end
      end
      PH_HELD: begin
        if (same && (mask_i != '0)) begin
          hold_d = hold_inc;
          if ((inc_x > long_x) && single) begin
            evt_o.valid      = step_i;
            evt_o.long_press = 1'b1;
            phase_d          = PH_IDLE;
          end
        end else if (mask_i == '0) begin
          phase_d = PH_IDLE;
          // short press window is open on both ends
          if ((hold_x < long_x) && (hold_x > short_x) && single) begin
            evt_o.valid = step_i;
          end
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      mask_q  <= '0;
      hold_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      mask_q  <= mask_i;
      hold_q  <= hold_d;
    end
  end

  a_evt_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.valid |-> step_i)
    else $error("event without a tick");

  a_evt_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.valid |=> (phase_q == PH_IDLE))
    else $error("event did not return to idle");

  a_short_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_o.valid && !evt_o.long_press) |-> (mask_i == '0))
    else $error("short press without release");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (phase_q == PH_HELD) && (&hold_q)) |=> (&hold_q))
    else $error("hold counter wrapped");

endmodule

// ----- rtl/core/button_short_long_press_detector_core.sv -----
// button_short_long_press_detector_core: top level of the press detector
// depends on bslp_pkg and bslp_track
//
// One input beat is one scan tick of three raw pin levels; key zero and key
// one are active low, the wake key active high. A single held key gives a
// long-press event once the hold count exceeds long_press_ticks, or a
// short-press event on release when the count lies strictly between
// short_press_ticks and long_press_ticks; combinations give nothing. The block
// takes one tick per cycle while the result register is not stalled; a tick
// passes through the input register, then through the phase logic into the
// result register. A stalled result register stops the input side once the
// input register is full.
module button_short_long_press_detector_core import bslp_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [THR_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // key0_level, key1_level, wake_level, zero fill
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata   // event_key[1:0], long_press, zero fill
);

  logic [THR_W-1:0]  long_ticks_q, short_ticks_q;
  logic              in_valid_q;
  logic [MASK_W-1:0] in_mask_q, in_mask_d;
  logic              advance;
  evt_t              evt;
  logic              out_valid_q;
  key_e              out_key_q;
  logic              out_long_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ticks_q  <= LONG_TICKS_RESET;
      short_ticks_q <= SHORT_TICKS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_LONG:  long_ticks_q  <= cfg_wdata_i;
        CFG_IDX_SHORT: short_ticks_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pressed mask: bit 0 key zero, bit 1 key one, bit 2 wake key
  assign in_mask_d[MASK_KEY0] = ~s_axis_tdata[0];
  assign in_mask_d[MASK_KEY1] = ~s_axis_tdata[1];
  assign in_mask_d[MASK_WAKE] =  s_axis_tdata[2];

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mask_q <= in_mask_d;
    end
  end

  bslp_track #(
    .COUNT_BITS (COUNT_BITS)
  ) u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .mask_i        (in_mask_q),
    .long_ticks_i  (long_ticks_q),
    .short_ticks_i (short_ticks_q),
    .evt_o         (evt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= evt.valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && evt.valid) begin
      out_key_q  <= evt.key;
      out_long_q <= evt.long_press;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_long_q, out_key_q};

endmodule

// ----- test/button_short_long_press_detector_core_tb.sv -----
// button_short_long_press_detector_core_tb: self-checking bench for the press detector core,
// with a burst driver, a stalling event sink and a tick-level press tracker for predictions
// depends on bslp_pkg and button_short_long_press_detector_core
module button_short_long_press_detector_core_tb;
  import bslp_pkg::*;

  localparam int unsigned CNT_W      = COUNT_BITS_DEFAULT;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [2:0]  M_KEY0 = 3'b001 << MASK_KEY0;
  localparam logic [2:0]  M_KEY1 = 3'b001 << MASK_KEY1;
  localparam logic [2:0]  M_WAKE = 3'b001 << MASK_WAKE;
  localparam logic [2:0]  M_NONE = 3'b000;

  typedef struct packed {
    key_e key;
    logic long_press;
  } press_evt_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [THR_W-1:0]     cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = 8'h03;  // key0_level, key1_level, wake_level, zero fill
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;          // event_key[1:0], long_press, zero fill

  button_short_long_press_detector_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // pending scan ticks as raw levels {wake, key1, key0}, and events still owed by the block
  logic [2:0] tick_q[$];
  press_evt_t evt_q[$];
  int unsigned mismatch_cnt = 0;

  // press tracker state and threshold mirror
  logic [2:0]       mask_cur  = M_NONE;
  logic [2:0]       mask_prev = M_NONE;
  phase_e           track_ph  = PH_IDLE;
  logic [CNT_W-1:0] hold_cnt  = '0;
  logic [THR_W-1:0] long_thr  = LONG_TICKS_RESET;
  logic [THR_W-1:0] short_thr = SHORT_TICKS_RESET;

  function automatic logic is_single(input logic [2:0] m);
    return m == M_KEY0 || m == M_KEY1 || m == M_WAKE;
  endfunction

  function automatic key_e key_of(input logic [2:0] m);
    case (m)
      M_KEY1:  return KEY_ONE;
      M_WAKE:  return KEY_WAKE;
      default: return KEY_ZERO;
    endcase
  endfunction

  task automatic track_tick(input logic [2:0] lv);
    press_evt_t ev;
    mask_prev = mask_cur;
    mask_cur  = {lv[2], ~lv[1], ~lv[0]};
    if (track_ph == PH_IDLE) begin
      if (mask_cur != mask_prev && mask_cur != M_NONE) begin
        track_ph = PH_HELD;
        hold_cnt = '0;
      end
    end else if (mask_cur == mask_prev && mask_cur != M_NONE) begin
      if (hold_cnt != '1) hold_cnt = hold_cnt + 1'b1;
      if (hold_cnt > long_thr && is_single(mask_prev)) begin
        ev.key        = key_of(mask_prev);
        ev.long_press = 1'b1;
        evt_q.push_back(ev);
        track_ph = PH_IDLE;
      end
    end else if (mask_cur == M_NONE) begin
      // combinations and a mask change while held fall through silently
      track_ph = PH_IDLE;
      if (hold_cnt < long_thr && hold_cnt > short_thr && is_single(mask_prev)) begin
        ev.key        = key_of(mask_prev);
        ev.long_press = 1'b0;
        evt_q.push_back(ev);
      end
    end
  endtask

  function automatic logic busy();
    return tick_q.size() != 0 || s_axis_tvalid || evt_q.size() != 0;
  endfunction

  // sender: bursts of random length separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, tick_q.pop_front()};
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // sink: alternating ready and stall stretches
  int unsigned rdy_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rdy_left      <= 0;
    end else if (rdy_left != 0) begin
      rdy_left <= rdy_left - 1;
    end else begin
      m_axis_tready <= !m_axis_tready;
      rdy_left      <= m_axis_tready ? $urandom_range(0, 6) : $urandom_range(1, 40);
    end
  end

  // monitor: check the event beat first, then predict from the tick beat
  always @(posedge clk_i) begin
    press_evt_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (evt_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("unexpected event beat: key %0d long %0b data %h",
                     m_axis_tdata[1:0], m_axis_tdata[2], m_axis_tdata);
          mismatch_cnt++;
        end else begin
          want = evt_q.pop_front();
          if (m_axis_tdata[1:0] !== want.key || m_axis_tdata[2] !== want.long_press ||
              m_axis_tdata[7:3] !== 5'b0) begin
            if (mismatch_cnt < 10)
              $display("event mismatch: expected key %0d long %0b, got key %0d long %0b pad %h",
                       want.key, want.long_press, m_axis_tdata[1:0], m_axis_tdata[2],
                       m_axis_tdata[7:3]);
            mismatch_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) track_tick(s_axis_tdata[2:0]);
    end
  end

  // watchdog: no beat on either side for too long while work is pending
  int unsigned stall_cnt = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || !busy() || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt == STALL_LIMIT) begin
      $display("button_short_long_press_detector_core regression: fail");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic push_mask(input logic [2:0] m, input int unsigned n);
    repeat (n) tick_q.push_back({m[2], ~m[1], ~m[0]});
  endtask

  task automatic wait_quiet();
    do @(negedge clk_i); while (busy());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_IDX_LONG) long_thr = val;
    else short_thr = val;
  endtask

  task automatic set_thresholds(input logic [THR_W-1:0] lng, input logic [THR_W-1:0] sht);
    wait_quiet();
    // a tick that gives no event may still be in the two-stage pipe
    repeat (4) @(posedge clk_i);
    write_reg(CFG_IDX_LONG, lng);
    write_reg(CFG_IDX_SHORT, sht);
  endtask

  task automatic add_traffic(input int unsigned n_items);
    int unsigned base, sel, cap;
    logic [2:0]  ma, mb;
    base = tick_q.size();
    cap  = (long_thr < 40) ? int'(long_thr) + 3 : 40;
    while (tick_q.size() - base < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        ma = 3'b001 << $urandom_range(0, 2);
        push_mask(ma, $urandom_range(1, cap));
      end else if (sel < 68) begin
        ma = 3'($urandom_range(3, 7));
        if (ma == M_WAKE) ma = 3'b111;
        push_mask(ma, $urandom_range(1, cap));
      end else if (sel < 82) begin
        // mask change while held
        ma = 3'($urandom_range(1, 7));
        do mb = 3'($urandom_range(1, 7)); while (mb == ma);
        push_mask(ma, $urandom_range(1, cap / 2 + 1));
        push_mask(mb, $urandom_range(1, cap));
      end else begin
        repeat ($urandom_range(1, 6)) tick_q.push_back(3'($urandom));
      end
      push_mask(M_NONE, $urandom_range(1, 3));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset thresholds: short window, outside window, combination, mask change, long press
    push_mask(M_KEY0, 7);
    push_mask(M_NONE, 1);
    push_mask(M_KEY1, 6);
    push_mask(M_NONE, 1);
    push_mask(M_KEY0 | M_KEY1, 3);
    push_mask(M_NONE, 1);
    push_mask(M_KEY0, 2);
    push_mask(M_WAKE, 6);
    push_mask(M_NONE, 1);
    // fires at count 301, then the still-held key leaves the block idle
    push_mask(M_KEY1, 303);
    push_mask(M_NONE, 2);

    set_thresholds(16'd0, 16'd0);
    add_traffic(200);

    // long threshold the counter can never exceed
    set_thresholds(16'hFFFF, 16'd0);
    add_traffic(200);

    set_thresholds(16'd3, 16'hFFFF);
    add_traffic(200);

    set_thresholds(16'd12, 16'd3);
    add_traffic(200);

    set_thresholds(16'd1, 16'd0);
    add_traffic(200);

    wait_quiet();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("button_short_long_press_detector_core regression: pass");
    end else begin
      $display("button_short_long_press_detector_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/bslp_pkg.sv
rtl/core/bslp_track.sv
rtl/core/button_short_long_press_detector_core.sv
test/button_short_long_press_detector_core_tb.sv
